/* rtl/scpa_pkg.sv */
// Shared types, constants and defaults for the size-class pool allocator.
package scpa_pkg;

    localparam int CHUNK_BYTES_DEF = 16000;
    localparam int MAX_SMALL_DEF   = 4096;
    localparam int ALIGN_BYTES_DEF = 8;
    localparam int HEAP_CHUNKS_DEF = 16;

    localparam int ADDR_W = 18;
    localparam int SIZE_W = 32;
    localparam int OPEN_W = 5;

    typedef enum logic [1:0] {
        KIND_FREE  = 2'd0,
        KIND_ALLOC = 2'd1,
        KIND_KEEP  = 2'd2,
        KIND_MOVE  = 2'd3
    } kind_t;

    typedef enum logic [9:0] {
        ST_CLEAR   = 10'b00_0000_0001,
        ST_IDLE    = 10'b00_0000_0010,
        ST_DECODE  = 10'b00_0000_0100,
        ST_HEAD    = 10'b00_0000_1000,
        ST_POP     = 10'b00_0001_0000,
        ST_REM_WR  = 10'b00_0010_0000,
        ST_BUMP    = 10'b00_0100_0000,
        ST_FREE_RD = 10'b00_1000_0000,
        ST_FREE_WR = 10'b01_0000_0000,
        ST_FINISH  = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        logic clr;
        logic load;
        logic rd_head_new;
        logic head_chk;
        logic rd_link;
        logic rd_head_rem;
        logic pop;
        logic push_rem;
        logic bump;
        logic rd_head_old;
        logic push_old;
        logic finish;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  has_old;
        logic  new_large;
        logic  old_large;
        logic  old_zero;
        logic  fails;
        logic  head_hit;
        logic  rem_push;
        logic  clear_last;
    } sts_t;

endpackage

/* rtl/size_class_pool_allocator_core.sv */
// Top level of the size-class pool allocator: sequencer, datapath and checks.
//
// A request transfers when start is high and busy is low. Its result sits on the result
// ports with done high for exactly one cycle and must be taken then: the receiver cannot
// stall. Busy falls in that same cycle, so the edge that takes a result can also take the
// next request. Every request passes a decode step and a finish step. Keep, free of a
// large or empty block, and large allocations need nothing more. A small free adds a
// class-head read and write. A small allocation adds a class-head check and either a
// link read (free-list hit) or a chunk bump, plus a class-head read and write to file a
// chunk remainder. A move adds a class-head read and write for the freed block. The
// class-head and link memories, each with one read and one write port and registered
// read data, set this sequence. After reset a clearing pass over the class heads keeps
// busy high.
// ALIGN_BYTES must be a power of two.
module size_class_pool_allocator_core #(
    parameter int CHUNK_BYTES = scpa_pkg::CHUNK_BYTES_DEF,
    parameter int MAX_SMALL   = scpa_pkg::MAX_SMALL_DEF,
    parameter int ALIGN_BYTES = scpa_pkg::ALIGN_BYTES_DEF,
    parameter int HEAP_CHUNKS = scpa_pkg::HEAP_CHUNKS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [scpa_pkg::ADDR_W-1:0] old_address,
    input  logic                        has_old,
    input  logic [scpa_pkg::SIZE_W-1:0] old_size,
    input  logic [scpa_pkg::SIZE_W-1:0] new_size,
    output logic                        done,
    output logic [scpa_pkg::ADDR_W-1:0] block_address,
    output logic                        granted,
    output logic                        from_system,
    output logic                        move_needed,
    output logic                        out_of_memory,
    output logic [scpa_pkg::SIZE_W-1:0] used_bytes,
    output logic [scpa_pkg::SIZE_W-1:0] chunk_bytes,
    output logic [scpa_pkg::SIZE_W-1:0] system_bytes,
    output logic [scpa_pkg::SIZE_W-1:0] realloc_calls,
    output logic [scpa_pkg::SIZE_W-1:0] realloc_kept,
    output logic [scpa_pkg::SIZE_W-1:0] net_bytes
);

    scpa_pkg::cmd_t cmd;
    scpa_pkg::sts_t sts;

    scpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    scpa_datapath #(
        .CHUNK_BYTES (CHUNK_BYTES),
        .MAX_SMALL   (MAX_SMALL),
        .ALIGN_BYTES (ALIGN_BYTES),
        .HEAP_CHUNKS (HEAP_CHUNKS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .old_address   (old_address),
        .has_old       (has_old),
        .old_size      (old_size),
        .new_size      (new_size),
        .done          (done),
        .block_address (block_address),
        .granted       (granted),
        .from_system   (from_system),
        .move_needed   (move_needed),
        .out_of_memory (out_of_memory),
        .used_bytes    (used_bytes),
        .chunk_bytes   (chunk_bytes),
        .system_bytes  (system_bytes),
        .realloc_calls (realloc_calls),
        .realloc_kept  (realloc_kept),
        .net_bytes     (net_bytes)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transfer did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in progress");

    a_grant_sys_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(granted && from_system))
        else $error("pool block and system block in one result");

    a_oom_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_of_memory) |-> (!granted && !move_needed && !from_system))
        else $error("out of memory with other flags set");

endmodule

/* rtl/scpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module scpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/scpa_ctrl.sv */
// Request sequencer of the size-class pool allocator.
module scpa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  scpa_pkg::sts_t sts,
    output scpa_pkg::cmd_t cmd,
    output logic          busy
);

    scpa_pkg::state_t state_reg, state_next, after_alloc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scpa_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        if (sts.kind == scpa_pkg::KIND_MOVE && !sts.old_zero && !sts.old_large)
        begin
            after_alloc = scpa_pkg::ST_FREE_RD;
        end
        else
        begin
            after_alloc = scpa_pkg::ST_FINISH;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            scpa_pkg::ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = scpa_pkg::ST_IDLE;
                end
            end
            scpa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = scpa_pkg::ST_DECODE;
                end
            end
            scpa_pkg::ST_DECODE:
            begin
                cmd.rd_head_new = 1'b1;
                case (sts.kind)
                    scpa_pkg::KIND_FREE:
                    begin
                        if (sts.has_old && !sts.old_zero && !sts.old_large)
                        begin
                            state_next = scpa_pkg::ST_FREE_RD;
                        end
                        else
                        begin
                            state_next = scpa_pkg::ST_FINISH;
                        end
                    end
                    scpa_pkg::KIND_KEEP:
                    begin
                        state_next = scpa_pkg::ST_FINISH;
                    end
                    default:
                    begin
                        if (sts.new_large)
                        begin
                            state_next = after_alloc;
                        end
                        else
                        begin
                            state_next = scpa_pkg::ST_HEAD;
                        end
                    end
                endcase
            end
            scpa_pkg::ST_HEAD:
            begin
                cmd.head_chk = 1'b1;
                if (sts.fails)
                begin
                    state_next = scpa_pkg::ST_FINISH;
                end
                else if (sts.head_hit)
                begin
                    cmd.rd_link = 1'b1;
                    state_next  = scpa_pkg::ST_POP;
                end
                else if (sts.rem_push)
                begin
                    cmd.rd_head_rem = 1'b1;
                    state_next      = scpa_pkg::ST_REM_WR;
                end
                else
                begin
                    state_next = scpa_pkg::ST_BUMP;
                end
            end
            scpa_pkg::ST_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = after_alloc;
            end
            scpa_pkg::ST_REM_WR:
            begin
                cmd.push_rem = 1'b1;
                state_next   = scpa_pkg::ST_BUMP;
            end
            scpa_pkg::ST_BUMP:
            begin
                cmd.bump   = 1'b1;
                state_next = after_alloc;
            end
            scpa_pkg::ST_FREE_RD:
            begin
                cmd.rd_head_old = 1'b1;
                state_next      = scpa_pkg::ST_FREE_WR;
            end
            scpa_pkg::ST_FREE_WR:
            begin
                cmd.push_old = 1'b1;
                state_next   = scpa_pkg::ST_FINISH;
            end
            scpa_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = scpa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = scpa_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != scpa_pkg::ST_IDLE);

endmodule

/* rtl/scpa_datapath.sv */
// Datapath: request registers, class heads, link store, chunk state and counters.
module scpa_datapath #(
    parameter int CHUNK_BYTES = scpa_pkg::CHUNK_BYTES_DEF,
    parameter int MAX_SMALL   = scpa_pkg::MAX_SMALL_DEF,
    parameter int ALIGN_BYTES = scpa_pkg::ALIGN_BYTES_DEF,
    parameter int HEAP_CHUNKS = scpa_pkg::HEAP_CHUNKS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  scpa_pkg::cmd_t              cmd,
    output scpa_pkg::sts_t              sts,
    input  logic [scpa_pkg::ADDR_W-1:0] old_address,
    input  logic                        has_old,
    input  logic [scpa_pkg::SIZE_W-1:0] old_size,
    input  logic [scpa_pkg::SIZE_W-1:0] new_size,
    output logic                        done,
    output logic [scpa_pkg::ADDR_W-1:0] block_address,
    output logic                        granted,
    output logic                        from_system,
    output logic                        move_needed,
    output logic                        out_of_memory,
    output logic [scpa_pkg::SIZE_W-1:0] used_bytes,
    output logic [scpa_pkg::SIZE_W-1:0] chunk_bytes,
    output logic [scpa_pkg::SIZE_W-1:0] system_bytes,
    output logic [scpa_pkg::SIZE_W-1:0] realloc_calls,
    output logic [scpa_pkg::SIZE_W-1:0] realloc_kept,
    output logic [scpa_pkg::SIZE_W-1:0] net_bytes
);

    localparam int AW          = scpa_pkg::ADDR_W;
    localparam int SW          = scpa_pkg::SIZE_W;
    localparam int OW          = scpa_pkg::OPEN_W;
    localparam int SH          = $clog2(ALIGN_BYTES);
    localparam int CLASS_COUNT = (MAX_SMALL + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int CLS_W       = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int LINK_AW     = AW - SH;
    localparam int LINK_DEPTH  = 1 << LINK_AW;
    localparam int HEAD_W      = LINK_AW + 1;
    localparam int REM_W       = $clog2(CHUNK_BYTES + 1);

    logic [AW-1:0]     oa_reg;
    logic              ho_reg;
    logic [SW-1:0]     os_reg, ns_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [OW-1:0]     opened_reg;
    logic [SW-1:0]     used_reg, chunk_reg, sys_reg, rcall_reg, rkept_reg, net_reg;
    logic [CLS_W-1:0]  clr_cnt_reg;
    logic              oom_reg, grant_reg;
    logic [AW-1:0]     addr_reg;

    logic [SW:0]       q_new, q_old;
    logic [SW-1:0]     a_new, a_old;
    logic [CLS_W-1:0]  cls_new, cls_old, rcls;
    logic              new_large, old_large, old_zero, keep, fits;
    scpa_pkg::kind_t   kind;
    logic [HEAD_W-1:0] head_rd, link_rd, pop_full;
    logic [LINK_AW-1:0] pop_idx, old_idx, ridx;
    logic [REM_W-1:0]  rem_q;
    logic [AW-1:0]     raddr;

    logic              h_we, h_re;
    logic [CLS_W-1:0]  h_waddr, h_raddr;
    logic [HEAD_W-1:0] h_wdata;
    logic              l_we;
    logic [LINK_AW-1:0] l_waddr;

    logic              alloc_hap, free_hap;
    logic [SW-1:0]     sys_add, sys_sub;

    assign q_new     = ({1'b0, ns_reg} + (SW+1)'(ALIGN_BYTES - 1)) >> SH;
    assign q_old     = ({1'b0, os_reg} + (SW+1)'(ALIGN_BYTES - 1)) >> SH;
    assign a_new     = SW'(q_new << SH);
    assign a_old     = SW'(q_old << SH);
    assign cls_new   = CLS_W'(q_new - (SW+1)'(1));
    assign cls_old   = CLS_W'(q_old - (SW+1)'(1));
    assign new_large = ns_reg > SW'(MAX_SMALL);
    assign old_large = os_reg > SW'(MAX_SMALL);
    assign old_zero  = (os_reg == '0);
    assign keep      = (ns_reg <= os_reg) || ((q_new == q_old) && !old_large);

    always_comb
    begin
        if (ns_reg == '0)
        begin
            kind = scpa_pkg::KIND_FREE;
        end
        else if (!ho_reg)
        begin
            kind = scpa_pkg::KIND_ALLOC;
        end
        else if (keep)
        begin
            kind = scpa_pkg::KIND_KEEP;
        end
        else
        begin
            kind = scpa_pkg::KIND_MOVE;
        end
    end

    assign fits     = SW'(rem_reg) >= a_new;
    assign rem_q    = rem_reg >> SH;
    assign rcls     = CLS_W'(rem_q - REM_W'(1));
    assign raddr    = AW'(chunk_reg - SW'(rem_reg));
    assign ridx     = raddr[AW-1:SH];
    assign old_idx  = oa_reg[AW-1:SH];
    assign pop_full = head_rd - HEAD_W'(1);
    assign pop_idx  = pop_full[HEAD_W-1] ? '0 : pop_full[LINK_AW-1:0];

    assign sts.kind       = kind;
    assign sts.has_old    = ho_reg;
    assign sts.new_large  = new_large;
    assign sts.old_large  = old_large;
    assign sts.old_zero   = old_zero;
    assign sts.head_hit   = (head_rd != '0);
    assign sts.fails      = (head_rd == '0) && !fits &&
                            ((opened_reg >= OW'(HEAP_CHUNKS)) || (a_new > SW'(CHUNK_BYTES)));
    assign sts.rem_push   = !fits && (rem_reg >= REM_W'(ALIGN_BYTES)) &&
                            (rem_q <= REM_W'(CLASS_COUNT));
    assign sts.clear_last = (clr_cnt_reg == CLS_W'(CLASS_COUNT - 1));

    assign h_re    = cmd.rd_head_new | cmd.rd_head_rem | cmd.rd_head_old;
    assign h_raddr = cmd.rd_head_rem ? rcls : (cmd.rd_head_old ? cls_old : cls_new);
    assign h_we    = cmd.clr | cmd.pop | cmd.push_rem | cmd.push_old;

    always_comb
    begin
        if (cmd.clr)
        begin
            h_waddr = clr_cnt_reg;
            h_wdata = '0;
        end
        else if (cmd.pop)
        begin
            h_waddr = cls_new;
            h_wdata = link_rd;
        end
        else if (cmd.push_rem)
        begin
            h_waddr = rcls;
            h_wdata = {1'b0, ridx} + HEAD_W'(1);
        end
        else
        begin
            h_waddr = cls_old;
            h_wdata = {1'b0, old_idx} + HEAD_W'(1);
        end
    end

    assign l_we    = cmd.push_rem | cmd.push_old;
    assign l_waddr = cmd.push_rem ? ridx : old_idx;

    scpa_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (CLASS_COUNT)
    ) u_heads (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .re    (h_re),
        .raddr (h_raddr),
        .rdata (head_rd)
    );

    scpa_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (LINK_DEPTH)
    ) u_links (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (head_rd),
        .re    (cmd.rd_link),
        .raddr (pop_idx),
        .rdata (link_rd)
    );

    assign alloc_hap = ((kind == scpa_pkg::KIND_ALLOC) || (kind == scpa_pkg::KIND_MOVE)) &&
                       !oom_reg;
    assign free_hap  = (((kind == scpa_pkg::KIND_FREE) && ho_reg) ||
                        (kind == scpa_pkg::KIND_MOVE)) && !oom_reg && !old_zero;
    assign sys_add   = (alloc_hap && new_large) ? ns_reg : '0;
    assign sys_sub   = (free_hap && old_large) ? os_reg : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            oa_reg <= old_address;
            ho_reg <= has_old;
            os_reg <= old_size;
            ns_reg <= new_size;
        end
        if (cmd.bump)
        begin
            addr_reg <= fits ? raddr : AW'(chunk_reg);
        end
        else if (cmd.pop)
        begin
            addr_reg <= {pop_idx, SH'(0)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            rem_reg       <= '0;
            opened_reg    <= '0;
            used_reg      <= '0;
            chunk_reg     <= '0;
            sys_reg       <= '0;
            rcall_reg     <= '0;
            rkept_reg     <= '0;
            net_reg       <= '0;
            oom_reg       <= 1'b0;
            grant_reg     <= 1'b0;
            done          <= 1'b0;
            block_address <= '0;
            granted       <= 1'b0;
            from_system   <= 1'b0;
            move_needed   <= 1'b0;
            out_of_memory <= 1'b0;
        end
        else
        begin
            done <= cmd.finish;
            if (cmd.clr)
            begin
                clr_cnt_reg <= clr_cnt_reg + CLS_W'(1);
            end
            if (cmd.load)
            begin
                oom_reg   <= 1'b0;
                grant_reg <= 1'b0;
            end
            if (cmd.head_chk)
            begin
                oom_reg <= sts.fails;
            end
            if (cmd.pop)
            begin
                grant_reg <= 1'b1;
                used_reg  <= used_reg + a_new;
            end
            if (cmd.bump)
            begin
                grant_reg <= 1'b1;
                used_reg  <= used_reg + a_new;
                if (fits)
                begin
                    rem_reg <= rem_reg - REM_W'(a_new);
                end
                else
                begin
                    rem_reg    <= REM_W'(CHUNK_BYTES) - REM_W'(a_new);
                    opened_reg <= opened_reg + OW'(1);
                    chunk_reg  <= chunk_reg + SW'(CHUNK_BYTES);
                end
            end
            if (cmd.push_old)
            begin
                used_reg <= used_reg - a_old;
            end
            if (cmd.finish)
            begin
                sys_reg <= sys_reg + sys_add - sys_sub;
                if ((kind == scpa_pkg::KIND_KEEP) ||
                    ((kind == scpa_pkg::KIND_MOVE) && !oom_reg))
                begin
                    rcall_reg <= rcall_reg + SW'(1);
                end
                if (kind == scpa_pkg::KIND_KEEP)
                begin
                    rkept_reg <= rkept_reg + SW'(1);
                end
                if (!oom_reg)
                begin
                    net_reg <= net_reg + ns_reg - os_reg;
                end
                if ((kind == scpa_pkg::KIND_KEEP) && !old_large)
                begin
                    block_address <= oa_reg;
                    granted       <= 1'b1;
                end
                else
                begin
                    block_address <= grant_reg ? addr_reg : '0;
                    granted       <= grant_reg;
                end
                from_system   <= (alloc_hap && new_large) ||
                                 ((kind == scpa_pkg::KIND_FREE) && free_hap && old_large) ||
                                 ((kind == scpa_pkg::KIND_KEEP) && old_large);
                move_needed   <= (kind == scpa_pkg::KIND_MOVE) && !oom_reg;
                out_of_memory <= oom_reg;
            end
        end
    end

    assign used_bytes    = used_reg;
    assign chunk_bytes   = chunk_reg;
    assign system_bytes  = sys_reg;
    assign realloc_calls = rcall_reg;
    assign realloc_kept  = rkept_reg;
    assign net_bytes     = net_reg;

endmodule
